[sv/spfal_pkg.sv]
package spfal_pkg;

  // Field widths of the request and result items
  localparam int unsigned ENT_W      = 10;
  localparam int unsigned AREA_W     = 16;
  localparam int unsigned FLAG_W     = 8;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned IN_PAD_W   = IN_DATA_W - ENT_W - AREA_W - FLAG_W - IDX_W;

  // Request kinds carried in s_axis_tuser
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Request payload as packed in s_axis_tdata, entity number in the lowest bits
  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic [IDX_W-1:0]    slot_index;
    logic [FLAG_W-1:0]   entry_flags;
    logic [AREA_W-1:0]   area_number;
    logic [ENT_W-1:0]    entity_number;
  } req_data_t;

endpackage

[sv/slot_pool_free_and_active_lists.sv]
// Slot pool with a singly linked free list and a doubly linked active list behind
// a head node. An add (tuser = 0) pops the free head, links it in right after the
// head node, stores entity number, area number and flags in the slot and maps the
// entity to it; a remove (tuser = 1) unlinks the slot, pushes it onto the free list
// and clears the map entry of the entity stored there. Each accepted request that
// does work goes through accept, a link-memory read (ST_RD) and the write states
// ST_W1 and ST_W2, split as the next-link memory's single write port takes two
// updates per request. A failed add (pool empty) or a remove with slot_index beyond
// the pool goes straight from accept to ST_FIN. The result waits in an output
// register, so the block takes the next request while it is still held. After reset
// a clearing pass over max(SLOTS + 1, ENTITIES) addresses (1024 at the defaults)
// builds the free chain and empties the entity map; tready stays low until it ends.
module slot_pool_free_and_active_lists #(
  parameter int unsigned SLOTS    = 256,
  parameter int unsigned ENTITIES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entity_number[9:0], area_number[25:10], entry_flags[33:26], slot_index[41:34]
  input  logic [spfal_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // granted_slot[7:0]
  output logic [spfal_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // ok[0]
  output logic                                m_axis_tuser
);
  import spfal_pkg::*;

  localparam int unsigned NODES = SLOTS + 1;
  localparam int unsigned HEAD  = SLOTS;
  localparam int unsigned NIL   = SLOTS + 1;
  localparam int unsigned LW    = $clog2(SLOTS + 2);
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned MW    = $clog2(ENTITIES);
  localparam int unsigned MAXN  = (NODES > ENTITIES) ? NODES : ENTITIES;
  localparam int unsigned CW    = $clog2(MAXN);
  localparam logic [LW-1:0] HEAD_L = LW'(HEAD);
  localparam logic [LW-1:0] NIL_L  = LW'(NIL);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_W1   = 3'd2;
  localparam logic [2:0] ST_W2   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Link, slot and map memories
  logic [LW-1:0]            next_mem [NODES];
  logic [LW-1:0]            prev_mem [NODES];
  logic [ENT_W-1:0]         ent_mem  [SLOTS];
  logic [AREA_W+FLAG_W-1:0] data_mem [SLOTS];
  logic [LW-1:0]            map_mem  [ENTITIES];

  logic [2:0]       state_q, state_d;
  logic             clr_busy_q;
  logic [CW-1:0]    clr_q;
  logic [LW-1:0]    free_head_q, free_head_d;
  logic             req_rm_q;
  logic [ENT_W-1:0] ent_q;
  logic [AREA_W-1:0] area_q;
  logic [FLAG_W-1:0] flg_q;
  logic [IDX_W-1:0] idx_q;
  logic [LW-1:0]    slot_q;
  logic             ok_q;
  logic             out_valid_q;
  logic [OUT_DATA_W-1:0] out_slot_q;
  logic             out_ok_q;

  logic [LW-1:0]    nl_rd0_q, nl_rd1_q, pl_rd_q;
  logic [ENT_W-1:0] ent_rd_q;

  req_data_t        req;
  logic             in_fire, out_free, out_load;
  logic [31:0]      idx_ext, fh_ext, ent_q_ext, ent_rd_ext, clr_ext, slot_ext;
  logic [31:0]      after_ext, p_ext, n_ext, nl_wa_ext, pl_wa_ext;

  logic             nl_we, pl_we, map_we, slot_we;
  logic [LW-1:0]    nl_wa, nl_wd, pl_wa, pl_wd, map_wd;
  logic [31:0]      map_wa_ext;

  assign req           = req_data_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = ((state_q == ST_W2) || (state_q == ST_FIN)) && out_free;

  assign idx_ext    = 32'(req.slot_index);
  assign fh_ext     = 32'(free_head_q);
  assign ent_q_ext  = 32'(ent_q);
  assign ent_rd_ext = 32'(ent_rd_q);
  assign clr_ext    = 32'(clr_q);
  assign slot_ext   = 32'(slot_q);
  assign after_ext  = 32'(nl_rd1_q);
  assign p_ext      = 32'(pl_rd_q);
  assign n_ext      = 32'(nl_rd0_q);
  assign nl_wa_ext  = 32'(nl_wa);
  assign pl_wa_ext  = 32'(pl_wa);

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == REQ_ADD) begin
            state_d = (fh_ext < SLOTS) ? ST_RD : ST_FIN;
          end else begin
            state_d = (idx_ext < SLOTS) ? ST_RD : ST_FIN;
          end
        end
      end
      ST_RD: state_d = ST_W1;
      ST_W1: begin
        state_d = ST_W2;
        if (!req_rm_q) begin
          free_head_d = nl_rd0_q;
        end
      end
      ST_W2: begin
        state_d = out_free ? ST_IDLE : ST_FIN;
        if (req_rm_q) begin
          free_head_d = slot_q;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Write port selection: clearing pass first, then the two write steps of a request
  always_comb begin
    nl_we      = 1'b0;
    nl_wa      = slot_q;
    nl_wd      = nl_rd1_q;
    pl_we      = 1'b0;
    pl_wa      = slot_q;
    pl_wd      = HEAD_L;
    map_we     = 1'b0;
    map_wa_ext = ent_q_ext;
    map_wd     = slot_q;
    slot_we    = 1'b0;
    if (clr_busy_q) begin
      nl_we      = clr_ext < NODES;
      nl_wa      = LW'(clr_ext);
      nl_wd      = (clr_ext == HEAD) ? HEAD_L :
                   (clr_ext == SLOTS - 1) ? NIL_L : LW'(clr_ext + 32'd1);
      pl_we      = clr_ext < NODES;
      pl_wa      = LW'(clr_ext);
      pl_wd      = (clr_ext == HEAD) ? HEAD_L : NIL_L;
      map_we     = clr_ext < ENTITIES;
      map_wa_ext = clr_ext;
      map_wd     = NIL_L;
    end else if (state_q == ST_W1) begin
      if (!req_rm_q) begin
        nl_we   = 1'b1;
        nl_wa   = slot_q;
        nl_wd   = nl_rd1_q;
        pl_we   = 1'b1;
        pl_wa   = slot_q;
        pl_wd   = HEAD_L;
        slot_we = 1'b1;
        map_we  = ent_q_ext < ENTITIES;
      end else begin
        // drop link writes that point to no node
        nl_we = p_ext < NODES;
        nl_wa = pl_rd_q;
        nl_wd = nl_rd0_q;
        pl_we = n_ext < NODES;
        pl_wa = nl_rd0_q;
        pl_wd = pl_rd_q;
      end
    end else if (state_q == ST_W2) begin
      if (!req_rm_q) begin
        nl_we = 1'b1;
        nl_wa = HEAD_L;
        nl_wd = slot_q;
        pl_we = after_ext < NODES;
        pl_wa = nl_rd1_q;
        pl_wd = slot_q;
      end else begin
        nl_we      = 1'b1;
        nl_wa      = slot_q;
        nl_wd      = free_head_q;
        map_we     = ent_rd_ext < ENTITIES;
        map_wa_ext = ent_rd_ext;
        map_wd     = NIL_L;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      next_mem[nl_wa[NW-1:0]] <= nl_wd;
    end
    if (state_q == ST_RD) begin
      nl_rd0_q <= next_mem[slot_q[NW-1:0]];
      nl_rd1_q <= next_mem[HEAD_L[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      prev_mem[pl_wa[NW-1:0]] <= pl_wd;
    end
    if (state_q == ST_RD) begin
      pl_rd_q <= prev_mem[slot_q[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      ent_mem[slot_q[SW-1:0]]  <= ent_q;
      data_mem[slot_q[SW-1:0]] <= {flg_q, area_q};
    end
    if (state_q == ST_RD) begin
      ent_rd_q <= ent_mem[slot_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa_ext[MW-1:0]] <= map_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + CW'(1);
        if (clr_ext == MAXN - 1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_rm_q <= s_axis_tuser;
      ent_q    <= req.entity_number;
      area_q   <= req.area_number;
      flg_q    <= req.entry_flags;
      idx_q    <= req.slot_index;
      if (s_axis_tuser == REQ_ADD) begin
        slot_q <= free_head_q;
        ok_q   <= fh_ext < SLOTS;
      end else begin
        slot_q <= LW'(idx_ext);
        ok_q   <= idx_ext < SLOTS;
      end
    end
    if (out_load) begin
      out_ok_q   <= ok_q;
      out_slot_q <= (ok_q && !req_rm_q) ? slot_ext[OUT_DATA_W-1:0] : idx_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_slot_q;
  assign m_axis_tuser  = out_ok_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_busy_q || state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("request accepted while busy");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RD || state_q == ST_FIN))
    else $error("accepted request did not start");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_W2 && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished request produced no result");

  a_link_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nl_we |-> nl_wa_ext < NODES) and (pl_we |-> pl_wa_ext < NODES))
    else $error("link write outside node range");
`endif

endmodule
